FILE: src/slru_pkg.sv
// Shared constants, codes and controller/datapath command types for the SLRU byte-budget block.
// No dependencies; every other file of the block refers to this package by scoped names.
`timescale 1ns / 1ps

package slru_pkg;

	localparam int ENTRIES_DEF   = 64;
	localparam int TAG_BITS_DEF  = 32;
	localparam int SIZE_BITS_DEF = 24;

	localparam int KEY_W   = 32;
	localparam int BYTES_W = 24;
	localparam int CMD_W   = 3;
	localparam int TOTAL_W = 30;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

	localparam logic [CMD_W-1:0] CMD_TOUCH   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_RESTORE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_EVICT   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_LOOKUP  = 3'd4;

	// Which slot a load step reads.
	typedef enum logic [1:0] {
		LD_MATCH = 2'd0,
		LD_FREE  = 2'd1,
		LD_EVICT = 2'd2,
		LD_PTAIL = 2'd3
	} ld_sel_t;

	// Which segment an attach step targets.
	typedef enum logic [1:0] {
		SEG_PROB = 2'd0,
		SEG_PROT = 2'd1,
		SEG_REQ  = 2'd2
	} seg_sel_t;

	typedef struct packed {
		logic     start;
		logic     search;
		logic     load;
		ld_sel_t  sel;
		logic     set_hit;
		logic     set_full;
		logic     detach;
		logic     drop;
		logic     cap_evict;
		logic     att_a;
		logic     att_b;
		seg_sel_t seg;
		logic     new_size;
		logic     insert;
		logic     upd_seg;
		logic     lookup;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             found;
		logic             free_ok;
		logic             evict_ok;
		logic             demote_go;
		logic             old_prot;
	} dp_stat_t;

endpackage

FILE: src/slru_if.sv
// Valid/ready channel interfaces for the request and result beats of the SLRU block.
// Depends on slru_pkg for the field widths.
`timescale 1ns / 1ps

interface slru_req_if;
	logic                          valid;
	logic                          ready;
	logic [slru_pkg::CMD_W-1:0]    cmd;
	logic [slru_pkg::KEY_W-1:0]    key_tag;
	logic [slru_pkg::BYTES_W-1:0]  entry_bytes;
	logic                          restore_segment;

	modport source (output valid, cmd, key_tag, entry_bytes, restore_segment, input ready);
	modport sink   (input valid, cmd, key_tag, entry_bytes, restore_segment, output ready);
endinterface

interface slru_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          segment_out;
	logic                          hit;
	logic                          evicted_valid;
	logic [slru_pkg::KEY_W-1:0]    evicted_key;
	logic [slru_pkg::BYTES_W-1:0]  evicted_bytes;
	logic [slru_pkg::TOTAL_W-1:0]  total_bytes;
	logic                          is_empty;
	logic                          table_full;

	modport source (output valid, segment_out, hit, evicted_valid, evicted_key, evicted_bytes,
		total_bytes, is_empty, table_full, input ready);
	modport sink   (input valid, segment_out, hit, evicted_valid, evicted_key, evicted_bytes,
		total_bytes, is_empty, table_full, output ready);
endinterface

FILE: src/slru_byte_budget_policy.sv
// Top level of the segmented LRU byte-budget block: joins the controller and the datapath.
// Depends on slru_pkg, the channel interfaces in slru_if.sv, slru_ctrl and slru_dp.
`timescale 1ns / 1ps

// Channel    Direction  Payload
// req        in         cmd, key_tag, entry_bytes, restore_segment
// rsp        out        segment_out, hit, evicted_valid, evicted_key, evicted_bytes,
//                       total_bytes, is_empty, table_full
// cfg        in         cfg_we, cfg_wdata (protected_max_bytes, no read-back)
//
// One command is worked at a time. From the accepted request beat, a touch miss that inserts
// steps through compare, decode, two attach writes and finish. A protected touch hit adds a
// detach; a probationary one adds a detach and the budget check, plus a detach, two attach
// writes and the next check per demoted entry. A restore runs like an insert, with a detach
// and a free-slot load first when it replaces a present copy. Evict and remove add a detach
// and lookup a slot read after decode when they find an entry; else decode goes to finish,
// as for a refused insert. The next request beat can be accepted in the cycle after the
// result is loaded. The head link memory is single-port, so each attach writes it twice.
// Reset clears the valid bits, the list ends, the byte counters and the budget register; the
// slot memories are not cleared and no entry is read before it is written.
// The result register lets a new request beat in while the last result waits; the block
// holds its final cycle only when a second result would overwrite one not yet taken.

module slru_byte_budget_policy #(
	parameter int ENTRIES   = slru_pkg::ENTRIES_DEF,
	parameter int TAG_BITS  = slru_pkg::TAG_BITS_DEF,
	parameter int SIZE_BITS = slru_pkg::SIZE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [slru_pkg::TOTAL_W-1:0] cfg_wdata,
	slru_req_if.sink                     req,
	slru_rsp_if.source                   rsp
);

	// Command and status between sequencer and datapath.
	slru_pkg::dp_cmd_t  dc;
	slru_pkg::dp_stat_t st;

	slru_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.st        (st),
		.dc        (dc)
	);

	// The datapath latches the request fields on the accepted beat and keeps the result
	// register that drives the response payload.
	slru_dp #(
		.ENTRIES   (ENTRIES),
		.TAG_BITS  (TAG_BITS),
		.SIZE_BITS (SIZE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_cmd    (req.cmd),
		.in_key    (req.key_tag),
		.in_bytes  (req.entry_bytes),
		.in_rseg   (req.restore_segment),
		.dc        (dc),
		.st        (st),
		.o_seg     (rsp.segment_out),
		.o_hit     (rsp.hit),
		.o_evv     (rsp.evicted_valid),
		.o_evk     (rsp.evicted_key),
		.o_evb     (rsp.evicted_bytes),
		.o_total   (rsp.total_bytes),
		.o_empty   (rsp.is_empty),
		.o_full    (rsp.table_full)
	);

endmodule

FILE: src/slru_ctrl.sv
// Sequencing state machine of the SLRU block: steps the datapath through search, detach,
// attach and demotion. Depends on slru_pkg for the command and status structs.
`timescale 1ns / 1ps

module slru_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  slru_pkg::dp_stat_t st,
	output slru_pkg::dp_cmd_t  dc
);

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_CMP  = 10'b0000000010,
		S_DEC  = 10'b0000000100,
		S_DET  = 10'b0000001000,
		S_FLD  = 10'b0000010000,
		S_ATA  = 10'b0000100000,
		S_ATB  = 10'b0001000000,
		S_DCHK = 10'b0010000000,
		S_LKUP = 10'b0100000000,
		S_FIN  = 10'b1000000000
	} state_t;

	state_t state_q, state_d;
	logic   demote_q, demote_d;
	logic   out_valid_q;

	assign out_valid = out_valid_q;
	assign in_ready  = (state_q == S_IDLE);

	always_comb begin
		dc       = '0;
		state_d  = state_q;
		demote_d = demote_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					dc.start = 1'b1;
					demote_d = 1'b0;
					state_d  = S_CMP;
				end
			end
			S_CMP: begin
				dc.search = 1'b1;
				state_d   = S_DEC;
			end
			S_DEC: begin
				state_d = S_FIN;
				case (st.cmd)
					slru_pkg::CMD_TOUCH, slru_pkg::CMD_RESTORE: begin
						dc.set_hit = 1'b1;
						if (st.found) begin
							dc.load = 1'b1;
							dc.sel  = slru_pkg::LD_MATCH;
							state_d = S_DET;
						end else if (st.free_ok) begin
							dc.load = 1'b1;
							dc.sel  = slru_pkg::LD_FREE;
							state_d = S_ATA;
						end else begin
							dc.set_full = 1'b1;
						end
					end
					slru_pkg::CMD_EVICT: begin
						if (st.evict_ok) begin
							dc.load = 1'b1;
							dc.sel  = slru_pkg::LD_EVICT;
							state_d = S_DET;
						end
					end
					slru_pkg::CMD_REMOVE: begin
						dc.set_hit = 1'b1;
						if (st.found) begin
							dc.load = 1'b1;
							dc.sel  = slru_pkg::LD_MATCH;
							state_d = S_DET;
						end
					end
					slru_pkg::CMD_LOOKUP: begin
						dc.set_hit = 1'b1;
						if (st.found) begin
							dc.load = 1'b1;
							dc.sel  = slru_pkg::LD_MATCH;
							state_d = S_LKUP;
						end
					end
					default: begin
						state_d = S_FIN;
					end
				endcase
			end
			S_DET: begin
				dc.detach    = 1'b1;
				dc.drop      = !demote_q && (st.cmd != slru_pkg::CMD_TOUCH);
				dc.cap_evict = (st.cmd == slru_pkg::CMD_EVICT);
				if (demote_q || st.cmd == slru_pkg::CMD_TOUCH) begin
					state_d = S_ATA;
				end else if (st.cmd == slru_pkg::CMD_RESTORE) begin
					state_d = S_FLD;
				end else begin
					state_d = S_FIN;
				end
			end
			S_FLD: begin
				if (st.free_ok) begin
					dc.load = 1'b1;
					dc.sel  = slru_pkg::LD_FREE;
					state_d = S_ATA;
				end else begin
					dc.set_full = 1'b1;
					state_d     = S_FIN;
				end
			end
			S_ATA: begin
				dc.att_a = 1'b1;
				if (demote_q) begin
					dc.seg = slru_pkg::SEG_PROB;
				end else if (st.cmd == slru_pkg::CMD_TOUCH) begin
					dc.new_size = 1'b1;
					dc.insert   = !st.found;
					dc.seg      = st.found ? slru_pkg::SEG_PROT : slru_pkg::SEG_PROB;
				end else begin
					dc.new_size = 1'b1;
					dc.insert   = 1'b1;
					dc.upd_seg  = 1'b1;
					dc.seg      = slru_pkg::SEG_REQ;
				end
				state_d = S_ATB;
			end
			S_ATB: begin
				dc.att_b = 1'b1;
				if (st.cmd == slru_pkg::CMD_TOUCH && st.found && (demote_q || !st.old_prot)) begin
					state_d = S_DCHK;
				end else begin
					state_d = S_FIN;
				end
			end
			S_DCHK: begin
				if (st.demote_go) begin
					dc.load  = 1'b1;
					dc.sel   = slru_pkg::LD_PTAIL;
					demote_d = 1'b1;
					state_d  = S_DET;
				end else begin
					state_d = S_FIN;
				end
			end
			S_LKUP: begin
				dc.lookup = 1'b1;
				state_d   = S_FIN;
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					dc.out_load = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			demote_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			demote_q <= demote_d;
			if (dc.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: src/slru_dp.sv
// Datapath of the SLRU block: tag match array, slot memories, segment ends, byte counters
// and the result register. Depends on slru_pkg; driven by slru_ctrl.
`timescale 1ns / 1ps

module slru_dp #(
	parameter int ENTRIES   = slru_pkg::ENTRIES_DEF,
	parameter int TAG_BITS  = slru_pkg::TAG_BITS_DEF,
	parameter int SIZE_BITS = slru_pkg::SIZE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [slru_pkg::TOTAL_W-1:0]   cfg_wdata,
	input  logic [slru_pkg::CMD_W-1:0]     in_cmd,
	input  logic [slru_pkg::KEY_W-1:0]     in_key,
	input  logic [slru_pkg::BYTES_W-1:0]   in_bytes,
	input  logic                           in_rseg,
	input  slru_pkg::dp_cmd_t              dc,
	output slru_pkg::dp_stat_t             st,
	output logic                           o_seg,
	output logic                           o_hit,
	output logic                           o_evv,
	output logic [slru_pkg::KEY_W-1:0]     o_evk,
	output logic [slru_pkg::BYTES_W-1:0]   o_evb,
	output logic [slru_pkg::TOTAL_W-1:0]   o_total,
	output logic                           o_empty,
	output logic                           o_full
);

	localparam int IW = $clog2(ENTRIES);
	localparam int LW = IW + 1;
	localparam int TW = (TAG_BITS < slru_pkg::KEY_W) ? TAG_BITS : slru_pkg::KEY_W;
	localparam int SW = (SIZE_BITS < slru_pkg::BYTES_W) ? SIZE_BITS : slru_pkg::BYTES_W;
	localparam int CW = (SW + IW + 1 > slru_pkg::TOTAL_W + 1) ? SW + IW + 1
		: slru_pkg::TOTAL_W + 1;
	localparam logic [LW-1:0] NIL = {1'b1, {IW{1'b0}}};

	logic [slru_pkg::CMD_W-1:0] cmd_q;
	logic [TW-1:0]              key_q;
	logic [SW-1:0]              size_q;
	logic                       rseg_q;

	logic [TW-1:0]      tag_q [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [ENTRIES-1:0] match_s1;

	logic [LW-1:0] mem_lh [ENTRIES];
	logic [LW-1:0] mem_lt [ENTRIES];
	logic          mem_sg [ENTRIES];
	logic [SW-1:0] mem_sz [ENTRIES];
	logic [TW-1:0] mem_tg [ENTRIES];

	logic [LW-1:0] rd_lh_q, rd_lt_q;
	logic          rd_sg_q;
	logic [SW-1:0] rd_sz_q;
	logic [TW-1:0] rd_tg_q;

	logic [LW-1:0]                ends_q [4];
	logic [IW-1:0]                cur_q;
	logic [CW-1:0]                prot_q, prob_q;
	logic [slru_pkg::TOTAL_W-1:0] max_q;

	logic          res_seg_q, res_hit_q, res_evv_q, res_full_q;
	logic [TW-1:0] res_evk_q;
	logic [SW-1:0] res_evb_q;

	logic [IW-1:0] match_idx, free_idx, ld_addr;
	logic          found;
	logic [LW-1:0] ev_link, a_old;
	logic          a_seg;
	logic [SW-1:0] a_size;
	logic [CW:0]   sum;

	logic          lh_we, lt_we;
	logic [IW-1:0] lh_wa, lt_wa;
	logic [LW-1:0] lh_wd, lt_wd;

	function automatic logic [CW-1:0] sat_sub(input logic [CW-1:0] a, input logic [CW-1:0] b);
		sat_sub = (a >= b) ? a - b : '0;
	endfunction

	// Lowest matching slot and lowest free slot.
	always_comb begin
		match_idx = '0;
		free_idx  = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (match_s1[i]) begin
				match_idx = IW'(i);
			end
			if (!valid_q[i]) begin
				free_idx = IW'(i);
			end
		end
	end

	assign found   = |match_s1;
	assign ev_link = ends_q[1][LW-1] ? ends_q[3] : ends_q[1];

	always_comb begin
		case (dc.sel)
			slru_pkg::LD_MATCH: ld_addr = match_idx;
			slru_pkg::LD_FREE:  ld_addr = free_idx;
			slru_pkg::LD_EVICT: ld_addr = ev_link[IW-1:0];
			slru_pkg::LD_PTAIL: ld_addr = ends_q[3][IW-1:0];
			default:            ld_addr = match_idx;
		endcase
	end

	always_comb begin
		case (dc.seg)
			slru_pkg::SEG_PROB: a_seg = 1'b0;
			slru_pkg::SEG_PROT: a_seg = 1'b1;
			slru_pkg::SEG_REQ:  a_seg = rseg_q;
			default:            a_seg = 1'b0;
		endcase
	end

	assign a_size = dc.new_size ? size_q : rd_sz_q;
	assign a_old  = a_seg ? ends_q[2] : ends_q[0];

	// Link write ports: unlink neighbors on detach, hook the old head on attach.
	always_comb begin
		lh_we = 1'b0;
		lh_wa = cur_q;
		lh_wd = NIL;
		lt_we = 1'b0;
		lt_wa = cur_q;
		lt_wd = a_old;
		if (dc.detach) begin
			lh_we = !rd_lt_q[LW-1];
			lh_wa = rd_lt_q[IW-1:0];
			lh_wd = rd_lh_q;
			lt_we = !rd_lh_q[LW-1];
			lt_wa = rd_lh_q[IW-1:0];
			lt_wd = rd_lt_q;
		end else if (dc.att_a) begin
			lh_we = !a_old[LW-1];
			lh_wa = a_old[IW-1:0];
			lh_wd = {1'b0, cur_q};
			lt_we = 1'b1;
		end else if (dc.att_b) begin
			lh_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (lh_we) begin
			mem_lh[lh_wa] <= lh_wd;
		end
		if (dc.load) begin
			rd_lh_q <= mem_lh[ld_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (lt_we) begin
			mem_lt[lt_wa] <= lt_wd;
		end
		if (dc.load) begin
			rd_lt_q <= mem_lt[ld_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (dc.att_a) begin
			mem_sg[cur_q] <= a_seg;
			mem_sz[cur_q] <= a_size;
		end
		if (dc.load) begin
			rd_sg_q <= mem_sg[ld_addr];
			rd_sz_q <= mem_sz[ld_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (dc.att_a && dc.insert) begin
			mem_tg[cur_q] <= key_q;
			tag_q[cur_q]  <= key_q;
		end
		if (dc.load) begin
			rd_tg_q <= mem_tg[ld_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (dc.start) begin
			cmd_q  <= in_cmd;
			key_q  <= in_key[TW-1:0];
			size_q <= in_bytes[SW-1:0];
			rseg_q <= in_rseg;
		end
		if (dc.search) begin
			for (int i = 0; i < ENTRIES; i++) begin
				match_s1[i] <= valid_q[i] && (tag_q[i] == key_q);
			end
		end
		if (dc.load) begin
			cur_q <= ld_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			prot_q  <= '0;
			prob_q  <= '0;
			max_q   <= '0;
			for (int i = 0; i < 4; i++) begin
				ends_q[i] <= NIL;
			end
		end else begin
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
			if (dc.detach) begin
				if (rd_lh_q[LW-1]) begin
					ends_q[{rd_sg_q, 1'b0}] <= rd_lt_q;
				end
				if (rd_lt_q[LW-1]) begin
					ends_q[{rd_sg_q, 1'b1}] <= rd_lh_q;
				end
				if (rd_sg_q) begin
					prot_q <= sat_sub(prot_q, CW'(rd_sz_q));
				end else begin
					prob_q <= sat_sub(prob_q, CW'(rd_sz_q));
				end
				if (dc.drop) begin
					valid_q[cur_q] <= 1'b0;
				end
			end
			if (dc.att_a) begin
				ends_q[{a_seg, 1'b0}] <= {1'b0, cur_q};
				if (a_old[LW-1]) begin
					ends_q[{a_seg, 1'b1}] <= {1'b0, cur_q};
				end
				if (a_seg) begin
					prot_q <= prot_q + CW'(a_size);
				end else begin
					prob_q <= prob_q + CW'(a_size);
				end
				if (dc.insert) begin
					valid_q[cur_q] <= 1'b1;
				end
			end
		end
	end

	assign sum = {1'b0, prot_q} + {1'b0, prob_q};

	always_ff @(posedge clk) begin
		if (dc.start) begin
			res_seg_q  <= 1'b0;
			res_hit_q  <= 1'b0;
			res_evv_q  <= 1'b0;
			res_evk_q  <= '0;
			res_evb_q  <= '0;
			res_full_q <= 1'b0;
		end
		if (dc.set_hit) begin
			res_hit_q <= found;
		end
		if (dc.set_full) begin
			res_full_q <= 1'b1;
		end
		if (dc.cap_evict) begin
			res_evv_q <= 1'b1;
			res_evk_q <= rd_tg_q;
			res_evb_q <= rd_sz_q;
		end
		// The touched key's segment follows it through promotion and any demotion.
		if (dc.att_a && (dc.upd_seg || (found && cur_q == match_idx))) begin
			res_seg_q <= a_seg;
		end
		if (dc.lookup) begin
			res_seg_q <= rd_sg_q;
		end
		if (dc.out_load) begin
			o_seg   <= res_seg_q;
			o_hit   <= res_hit_q;
			o_evv   <= res_evv_q;
			o_evk   <= slru_pkg::KEY_W'(res_evk_q);
			o_evb   <= slru_pkg::BYTES_W'(res_evb_q);
			o_total <= (sum > (CW + 1)'(slru_pkg::TOTAL_MAX)) ? slru_pkg::TOTAL_MAX
				: sum[slru_pkg::TOTAL_W-1:0];
			o_empty <= ends_q[0][LW-1] && ends_q[2][LW-1];
			o_full  <= res_full_q;
		end
	end

	assign st.cmd       = cmd_q;
	assign st.found     = found;
	assign st.free_ok   = ~&valid_q;
	assign st.evict_ok  = !ends_q[1][LW-1] || !ends_q[3][LW-1];
	assign st.demote_go = (prot_q > CW'(max_q)) && !ends_q[3][LW-1];
	assign st.old_prot  = rd_sg_q;

endmodule
